// ----- hw/rtl/mrbm_pkg.sv -----
// Shared types and constants for the mip residency budget manager.
// Used by the size module, the top level and the testbench; depends on nothing.
package mrbm_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [3:0]  MAX_MIPS = 4'd15;
  localparam logic [14:0] DIM_MAX  = 15'd16384;
  localparam logic [39:0] USED_MAX = 40'hFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    ACT_REGISTER   = 2'd0,
    ACT_UNREGISTER = 2'd1,
    ACT_REQUEST    = 2'd2,
    ACT_TICK       = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  localparam logic [1:0] PRIO_NORMAL = 2'd2;
  localparam logic [1:0] PRIO_LOW    = 2'd3;

  localparam logic [1:0] REG_BUDGET = 2'd0;
  localparam logic [1:0] REG_LOADS  = 2'd1;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] handle;
    logic [14:0] width;
    logic [14:0] height;
    logic [3:0]  mip_count;
    logic [3:0]  mip_level;
    logic [1:0]  priority_req;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [39:0] used_bytes;
    logic [15:0] pending_requests;
    logic [31:0] evicted_total;
    logic [6:0]  entry_count;
    logic [3:0]  loads_done;
  } out_word_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [14:0] w;
    logic [14:0] h;
    logic [3:0]  count;
    logic [3:0]  cur;
    logic [3:0]  req;
    logic [1:0]  prio;
    logic [31:0] last_use;
    logic [30:0] size;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE, S_FIND_RD, S_FIND_CHK, S_DECIDE, S_MUL, S_SUB, S_ADD, S_WR,
    S_CMP_RD, S_CMP_WR, S_TK_RD, S_TK_CHK, S_RC_RD, S_RC_CHK,
    S_EV_START, S_EV_RD, S_EV_CHK, S_EV_GET, S_TK_END, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    MODE_REG, MODE_REQ, MODE_UNREG, MODE_APPLY, MODE_EVICT
  } mode_t;

endpackage

// ----- hw/rtl/mrbm_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module mrbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/mrbm_mip_size.sv -----
// Byte estimate of one mip level: max(1, w>>m) * max(1, h>>m) * 4.
// Depends on mrbm_pkg.
module mrbm_mip_size
  import mrbm_pkg::*;
(
  input  logic [14:0] w,
  input  logic [14:0] h,
  input  logic [3:0]  mip,
  output logic [30:0] bytes
);

  logic [14:0] ws;
  logic [14:0] hs;
  logic [28:0] prod;

  always_comb begin
    ws = w >> mip;
    hs = h >> mip;
    if (ws == 15'd0) begin
      ws = 15'd1;
    end
    if (hs == 15'd0) begin
      hs = 15'd1;
    end
    // Both sides are at most 16384, so the product fits in 29 bits.
    prod  = 29'(ws) * 29'(hs);
    bytes = {prod, 2'b00};
  end

endmodule

// ----- hw/rtl/mip_residency_budget_manager_top.sv -----
// Top level of the mip residency budget manager.
// Depends on mrbm_pkg, mrbm_ram and mrbm_mip_size.
//
// Usage: one request word enters on req_valid/req_ready and exactly one
// response word leaves on rsp_valid/rsp_ready. The texture table lives in a
// 64-entry RAM with a registered read port; a small sequencer walks it one
// entry at a time, a read state then a check state, and drives one shared
// size multiplier and one 40-bit add/subtract unit. The block is not ready
// while it works on a word. Register, unregister and request first search
// the table for the handle; unregister then moves every later entry up by
// one. A frame tick runs up to four priority passes that apply changes, a
// recount of pending requests and then eviction steps until the byte total
// is within the budget or nothing is left loaded.
// Reset clears the entry count, byte total and all counters, sets the budget
// to zero and loads_per_tick to four. Table entries are not cleared; only
// entries below the count are ever read. A finished response waits in the
// output register while the receiver stalls, and the next request word is
// taken as soon as the sequencer is back in idle. Configuration writes are
// always ready and must only be issued while the block is idle.
module mip_residency_budget_manager_top
  import mrbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  in_word_t    req_word,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output out_word_t   rsp_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [39:0] cfg_data
);

  // Control state.
  state_t          state, state_next;
  logic            rsp_valid_q, rsp_valid_next;
  logic [CNT_W-1:0] tcount, tcount_next;
  logic [39:0]     used, used_next;
  logic [31:0]     tickc, tickc_next;
  logic [15:0]     pend, pend_next;
  logic [31:0]     evc, evc_next;
  logic [39:0]     budget, budget_next;
  logic [3:0]      lpt, lpt_next;

  // Working registers of the current word.
  mode_t           mode, mode_next;
  in_word_t        req_q, req_q_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [1:0]      pass, pass_next;
  logic [3:0]      done, done_next;
  logic [IDX_W-1:0] best, best_next;
  logic [31:0]     best_lu, best_lu_next;
  logic            found, found_next;
  logic [CNT_W-1:0] rc_n, rc_n_next;
  entry_t          ent, ent_next;
  logic [30:0]     nsize, nsize_next;
  logic [1:0]      status, status_next;
  out_word_t       rsp_q, rsp_q_next;

  // Table memory.
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;
  logic [30:0]      size_out;

  logic [3:0]  mc_c;
  logic [3:0]  ml_c;
  logic [40:0] sum;
  logic [CNT_W-1:0] idx_inc;

  mrbm_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  mrbm_mip_size u_size (
    .w    (ent.w),
    .h    (ent.h),
    .mip  (ent.cur),
    .bytes(size_out)
  );

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = rsp_valid_q;
  assign rsp_word  = rsp_q;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_next     = state;
    rsp_valid_next = rsp_valid_q && !rsp_ready;
    tcount_next    = tcount;
    used_next      = used;
    tickc_next     = tickc;
    pend_next      = pend;
    evc_next       = evc;
    budget_next    = budget;
    lpt_next       = lpt;
    mode_next      = mode;
    req_q_next     = req_q;
    idx_next       = idx;
    pass_next      = pass;
    done_next      = done;
    best_next      = best;
    best_lu_next   = best_lu;
    found_next     = found;
    rc_n_next      = rc_n;
    ent_next       = ent;
    nsize_next     = nsize;
    status_next    = status;
    rsp_q_next     = rsp_q;
    ram_we         = 1'b0;
    ram_waddr      = idx[IDX_W-1:0];
    ram_raddr      = idx[IDX_W-1:0];
    ram_wdata      = ent;
    idx_inc        = idx + 1'b1;
    sum            = {1'b0, used} + {10'd0, nsize};

    if (req_q.mip_count == 4'd0) begin
      mc_c = 4'd1;
    end else if (req_q.mip_count > MAX_MIPS) begin
      mc_c = MAX_MIPS;
    end else begin
      mc_c = req_q.mip_count;
    end
    ml_c = (req_q.mip_level >= ent.count) ? ent.count - 4'd1 : req_q.mip_level;

    if (cfg_valid) begin
      if (cfg_index == REG_BUDGET) begin
        budget_next = cfg_data;
      end else if (cfg_index == REG_LOADS) begin
        lpt_next = cfg_data[3:0];
      end
    end

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          req_q_next  = req_word;
          idx_next    = '0;
          pass_next   = '0;
          done_next   = '0;
          found_next  = 1'b0;
          status_next = ST_OK;
          state_next  = (req_word.action == ACT_TICK) ? S_TK_RD : S_FIND_RD;
        end
      end
      S_FIND_RD: begin
        state_next = (idx >= tcount) ? S_DECIDE : S_FIND_CHK;
      end
      S_FIND_CHK: begin
        if (ram_rdata.handle == req_q.handle) begin
          found_next = 1'b1;
          ent_next   = ram_rdata;
          state_next = S_DECIDE;
        end else begin
          idx_next   = idx_inc;
          state_next = S_FIND_RD;
        end
      end
      S_DECIDE: begin
        unique case (req_q.action)
          ACT_REGISTER: begin
            if (found) begin
              status_next = ST_DUPLICATE;
              state_next  = S_DONE;
            end else if (tcount == CNT_W'(TABLE_DEPTH)) begin
              status_next = ST_FULL;
              state_next  = S_DONE;
            end else begin
              ent_next.handle   = req_q.handle;
              ent_next.w        = (req_q.width > DIM_MAX) ? DIM_MAX : req_q.width;
              ent_next.h        = (req_q.height > DIM_MAX) ? DIM_MAX : req_q.height;
              ent_next.count    = mc_c;
              ent_next.cur      = mc_c - 4'd1;
              ent_next.req      = mc_c - 4'd1;
              ent_next.prio     = PRIO_NORMAL;
              ent_next.last_use = tickc;
              ent_next.size     = '0;
              idx_next          = tcount;
              mode_next         = MODE_REG;
              state_next        = S_MUL;
            end
          end
          ACT_UNREGISTER: begin
            if (!found) begin
              status_next = ST_NOT_FOUND;
              state_next  = S_DONE;
            end else begin
              mode_next  = MODE_UNREG;
              state_next = S_SUB;
            end
          end
          ACT_REQUEST: begin
            if (!found) begin
              status_next = ST_NOT_FOUND;
              state_next  = S_DONE;
            end else begin
              ent_next.req      = ml_c;
              ent_next.prio     = req_q.priority_req;
              ent_next.last_use = tickc;
              if (ml_c != ent.cur && pend != 16'hFFFF) begin
                pend_next = pend + 16'd1;
              end
              mode_next  = MODE_REQ;
              state_next = S_WR;
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_MUL: begin
        nsize_next = size_out;
        state_next = S_SUB;
      end
      S_SUB: begin
        used_next  = (used >= {9'd0, ent.size}) ? used - {9'd0, ent.size} : '0;
        state_next = (mode == MODE_UNREG) ? S_CMP_RD : S_ADD;
      end
      S_ADD: begin
        used_next     = sum[40] ? USED_MAX : sum[39:0];
        ent_next.size = nsize;
        state_next    = S_WR;
      end
      S_WR: begin
        ram_we = 1'b1;
        unique case (mode)
          MODE_REG: begin
            tcount_next = tcount + 1'b1;
            state_next  = S_DONE;
          end
          MODE_APPLY: begin
            done_next  = done + 4'd1;
            idx_next   = idx_inc;
            state_next = S_TK_RD;
          end
          MODE_EVICT: begin
            if (evc != 32'hFFFF_FFFF) begin
              evc_next = evc + 32'd1;
            end
            state_next = S_EV_START;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_CMP_RD: begin
        // Move every later entry up by one to close the gap.
        if (idx_inc >= tcount) begin
          tcount_next = tcount - 1'b1;
          state_next  = S_DONE;
        end else begin
          ram_raddr  = idx_inc[IDX_W-1:0];
          state_next = S_CMP_WR;
        end
      end
      S_CMP_WR: begin
        ram_we     = 1'b1;
        ram_wdata  = ram_rdata;
        idx_next   = idx_inc;
        state_next = S_CMP_RD;
      end
      S_TK_RD: begin
        if (done >= lpt || (idx >= tcount && pass == PRIO_LOW)) begin
          idx_next   = '0;
          rc_n_next  = '0;
          state_next = S_RC_RD;
        end else if (idx >= tcount) begin
          pass_next = pass + 2'd1;
          idx_next  = '0;
        end else begin
          state_next = S_TK_CHK;
        end
      end
      S_TK_CHK: begin
        if (ram_rdata.req != ram_rdata.cur && ram_rdata.prio == pass) begin
          ent_next          = ram_rdata;
          ent_next.cur      = ram_rdata.req;
          ent_next.last_use = tickc;
          mode_next         = MODE_APPLY;
          state_next        = S_MUL;
        end else begin
          idx_next   = idx_inc;
          state_next = S_TK_RD;
        end
      end
      S_RC_RD: begin
        if (idx >= tcount) begin
          pend_next  = {{(16-CNT_W){1'b0}}, rc_n};
          state_next = S_EV_START;
        end else begin
          state_next = S_RC_CHK;
        end
      end
      S_RC_CHK: begin
        if (ram_rdata.req != ram_rdata.cur) begin
          rc_n_next = rc_n + 1'b1;
        end
        idx_next   = idx_inc;
        state_next = S_RC_RD;
      end
      S_EV_START: begin
        if (used > budget && tcount != '0) begin
          idx_next   = '0;
          found_next = 1'b0;
          state_next = S_EV_RD;
        end else begin
          state_next = S_TK_END;
        end
      end
      S_EV_RD: begin
        if (idx >= tcount) begin
          if (found) begin
            ram_raddr  = best;
            idx_next   = {1'b0, best};
            state_next = S_EV_GET;
          end else begin
            state_next = S_TK_END;
          end
        end else begin
          state_next = S_EV_CHK;
        end
      end
      S_EV_CHK: begin
        // Oldest loaded entry wins; ties keep the earlier one.
        if (ram_rdata.size != '0 && (!found || ram_rdata.last_use < best_lu)) begin
          best_next    = idx[IDX_W-1:0];
          best_lu_next = ram_rdata.last_use;
          found_next   = 1'b1;
        end
        idx_next   = idx_inc;
        state_next = S_EV_RD;
      end
      S_EV_GET: begin
        ent_next  = ram_rdata;
        mode_next = MODE_EVICT;
        if (ram_rdata.cur >= ram_rdata.count - 4'd1) begin
          ent_next.cur = ram_rdata.count - 4'd1;
          nsize_next   = '0;
          state_next   = S_SUB;
        end else begin
          ent_next.cur = ram_rdata.cur + 4'd1;
          ent_next.req = ram_rdata.cur + 4'd1;
          state_next   = S_MUL;
        end
      end
      S_TK_END: begin
        if (tickc != 32'hFFFF_FFFF) begin
          tickc_next = tickc + 32'd1;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp_ready) begin
          rsp_q_next.status           = status;
          rsp_q_next.used_bytes       = used;
          rsp_q_next.pending_requests = pend;
          rsp_q_next.evicted_total    = evc;
          rsp_q_next.entry_count      = {{(7-CNT_W){1'b0}}, tcount};
          rsp_q_next.loads_done       = done;
          rsp_valid_next              = 1'b1;
          state_next                  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp_valid_q <= 1'b0;
      tcount      <= '0;
      used        <= '0;
      tickc       <= '0;
      pend        <= '0;
      evc         <= '0;
      budget      <= '0;
      lpt         <= 4'd4;
    end else begin
      state       <= state_next;
      rsp_valid_q <= rsp_valid_next;
      tcount      <= tcount_next;
      used        <= used_next;
      tickc       <= tickc_next;
      pend        <= pend_next;
      evc         <= evc_next;
      budget      <= budget_next;
      lpt         <= lpt_next;
    end
  end

  always_ff @(posedge clk) begin
    mode    <= mode_next;
    req_q   <= req_q_next;
    idx     <= idx_next;
    pass    <= pass_next;
    done    <= done_next;
    best    <= best_next;
    best_lu <= best_lu_next;
    found   <= found_next;
    rc_n    <= rc_n_next;
    ent     <= ent_next;
    nsize   <= nsize_next;
    status  <= status_next;
    rsp_q   <= rsp_q_next;
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    tcount <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state != S_IDLE)
    else $error("table written while idle");

  a_loads_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> done <= lpt)
    else $error("more changes applied than allowed");

  a_evict_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> evc >= $past(evc))
    else $error("eviction counter went down");
`endif

endmodule

// ----- test/mip_residency_budget_manager_top_tb.sv -----
// Testbench for the mip residency budget manager top level.
// Depends on mrbm_pkg and the block's RTL; a built-in predictor checks every response word.
module mip_residency_budget_manager_top_tb;
  import mrbm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Priority codes that the package does not name.
  localparam logic [1:0] PRIO_IMMEDIATE = 2'd0;
  localparam logic [1:0] PRIO_HIGH      = 2'd1;
  localparam int         POOL_SPAN      = 56;

  // Idling modes: none, sender idle, receiver stalling, both.
  localparam int MODE_BUSY = 0;
  localparam int MODE_SEND = 1;
  localparam int MODE_RECV = 2;
  localparam int MODE_BOTH = 3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  in_word_t    req_word = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  out_word_t   rsp_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_BUDGET;
  logic [39:0] cfg_data = '0;

  mip_residency_budget_manager_top uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_word  (rsp_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Shadow copy of one texture table entry.
  typedef struct {
    logic [15:0] handle;
    logic [14:0] w;
    logic [14:0] h;
    logic [3:0]  count;
    logic [3:0]  cur;
    logic [3:0]  req;
    logic [1:0]  prio;
    logic [31:0] last_use;
    logic [30:0] size;
  } texture_t;

  texture_t    textures[TABLE_DEPTH];
  int          tex_count = 0;
  logic [39:0] bytes_resident = '0;
  logic [31:0] frame_no = '0;
  logic [15:0] pending_cnt = '0;
  logic [31:0] evict_cnt = '0;
  logic [39:0] budget = '0;
  logic [3:0]  loads_limit = 4'd4;

  in_word_t  stim_q[$];
  out_word_t expected_q[$];
  int        mismatches = 0;
  int        idle_mode = MODE_BUSY;
  int        hold_request = 0;
  int        hold_left = 0;
  logic      req_took = 1'b0;
  logic [15:0] pool_base = '0;

  // Byte estimate of one mip level: each side floors at one pixel, four bytes a pixel.
  function automatic logic [30:0] level_bytes(logic [14:0] w, logic [14:0] h, logic [3:0] m);
    logic [14:0] a;
    logic [14:0] b;
    a = w >> m;
    b = h >> m;
    if (a == 0) a = 1;
    if (b == 0) b = 1;
    return 31'(a) * 31'(b) * 31'd4;
  endfunction

  function automatic void bytes_sub(logic [30:0] v);
    bytes_resident = (bytes_resident >= 40'(v)) ? bytes_resident - 40'(v) : '0;
  endfunction

  function automatic void bytes_add(logic [30:0] v);
    logic [40:0] s;
    s = {1'b0, bytes_resident} + 41'(v);
    bytes_resident = (s > {1'b0, USED_MAX}) ? USED_MAX : s[39:0];
  endfunction

  // Appends one word to the stimulus queue.
  function automatic void stim_add(in_word_t x);
    stim_q = {stim_q, x};
  endfunction

  function automatic int find_texture(logic [15:0] hnd);
    for (int i = 0; i < tex_count; i++)
      if (textures[i].handle == hnd) return i;
    return -1;
  endfunction

  // Evicts one mip step from the least recently used loaded texture.
  // Returns zero once every texture is unloaded.
  function automatic bit evict_step();
    int best;
    bit found;
    logic [30:0] ns;
    best = 0;
    found = 1'b0;
    for (int i = 0; i < tex_count; i++) begin
      if (textures[i].size == 0) continue;
      if (!found || textures[i].last_use < textures[best].last_use) begin
        best = i;
        found = 1'b1;
      end
    end
    if (!found) return 1'b0;
    if (textures[best].cur >= textures[best].count - 4'd1) begin
      bytes_sub(textures[best].size);
      textures[best].size = '0;
      textures[best].cur = textures[best].count - 4'd1;
    end else begin
      textures[best].cur = textures[best].cur + 4'd1;
      textures[best].req = textures[best].cur;
      ns = level_bytes(textures[best].w, textures[best].h, textures[best].cur);
      bytes_sub(textures[best].size);
      bytes_add(ns);
      textures[best].size = ns;
    end
    if (evict_cnt != 32'hFFFF_FFFF) evict_cnt = evict_cnt + 1;
    return 1'b1;
  endfunction

  function automatic logic [3:0] run_frame();
    int applied;
    int waiting;
    logic [30:0] ns;
    applied = 0;
    waiting = 0;
    for (int p = 0; p < 4; p++) begin
      for (int i = 0; i < tex_count; i++) begin
        if (applied >= loads_limit) break;
        if (textures[i].req == textures[i].cur) continue;
        if (textures[i].prio != 2'(p)) continue;
        ns = level_bytes(textures[i].w, textures[i].h, textures[i].req);
        bytes_sub(textures[i].size);
        bytes_add(ns);
        textures[i].cur = textures[i].req;
        textures[i].size = ns;
        textures[i].last_use = frame_no;
        applied++;
      end
    end
    for (int i = 0; i < tex_count; i++)
      if (textures[i].req != textures[i].cur) waiting++;
    pending_cnt = (waiting > 16'hFFFF) ? 16'hFFFF : 16'(waiting);
    while (bytes_resident > budget && tex_count > 0) begin
      if (!evict_step()) break;
    end
    if (frame_no != 32'hFFFF_FFFF) frame_no = frame_no + 1;
    return 4'(applied);
  endfunction

  // Updates the shadow table with one request word and returns the response it must cause.
  function automatic out_word_t predict_response(in_word_t w);
    out_word_t r;
    int k;
    logic [3:0] mc;
    logic [3:0] ml;
    r = '0;
    r.status = ST_OK;
    case (action_t'(w.action))
      ACT_REGISTER: begin
        if (find_texture(w.handle) >= 0) begin
          r.status = ST_DUPLICATE;
        end else if (tex_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          mc = (w.mip_count == 0) ? 4'd1 : w.mip_count;
          if (mc > MAX_MIPS) mc = MAX_MIPS;
          textures[tex_count].handle = w.handle;
          textures[tex_count].w = (w.width > DIM_MAX) ? DIM_MAX : w.width;
          textures[tex_count].h = (w.height > DIM_MAX) ? DIM_MAX : w.height;
          textures[tex_count].count = mc;
          textures[tex_count].cur = mc - 4'd1;
          textures[tex_count].req = mc - 4'd1;
          textures[tex_count].prio = PRIO_NORMAL;
          textures[tex_count].last_use = frame_no;
          textures[tex_count].size = level_bytes(textures[tex_count].w,
                                                 textures[tex_count].h, mc - 4'd1);
          bytes_add(textures[tex_count].size);
          tex_count++;
        end
      end
      ACT_UNREGISTER: begin
        k = find_texture(w.handle);
        if (k < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          bytes_sub(textures[k].size);
          for (int i = k; i + 1 < tex_count; i++) textures[i] = textures[i + 1];
          tex_count--;
        end
      end
      ACT_REQUEST: begin
        k = find_texture(w.handle);
        if (k < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          ml = (w.mip_level >= textures[k].count) ? textures[k].count - 4'd1 : w.mip_level;
          textures[k].req = ml;
          textures[k].prio = w.priority_req;
          textures[k].last_use = frame_no;
          if (ml != textures[k].cur && pending_cnt != 16'hFFFF) pending_cnt = pending_cnt + 1;
        end
      end
      default: r.loads_done = run_frame();
    endcase
    r.used_bytes = bytes_resident;
    r.pending_requests = pending_cnt;
    r.evicted_total = evict_cnt;
    r.entry_count = 7'(tex_count);
    return r;
  endfunction

  function automatic in_word_t make_word(action_t a, logic [15:0] hnd, int w, int h,
                                          int mc, int ml, logic [1:0] pr);
    in_word_t x;
    x.action = a;
    x.handle = hnd;
    x.width = 15'(w);
    x.height = 15'(h);
    x.mip_count = 4'(mc);
    x.mip_level = 4'(ml);
    x.priority_req = pr;
    return x;
  endfunction

  function automatic int rand_dim();
    int r;
    r = $urandom_range(99);
    if (r < 85) return $urandom_range(0, 512);
    if (r < 95) return $urandom_range(0, 32767);
    return (r < 98) ? 16384 : 0;
  endfunction

  // Random word: handles mostly come from a small pool so that most words hit the table.
  function automatic in_word_t rand_word(int reg_pct, int unreg_pct, int req_pct);
    in_word_t x;
    int r;
    x = '0;
    x.width = 15'(rand_dim());
    x.height = 15'(rand_dim());
    x.mip_count = 4'($urandom_range(15));
    x.mip_level = 4'($urandom_range(15));
    x.priority_req = 2'($urandom_range(3));
    x.handle = ($urandom_range(99) < 10) ? 16'($urandom) : pool_base + 16'($urandom_range(POOL_SPAN - 1));
    r = $urandom_range(99);
    if (r < reg_pct) x.action = ACT_REGISTER;
    else if (r < reg_pct + unreg_pct) x.action = ACT_UNREGISTER;
    else if (r < reg_pct + unreg_pct + req_pct) x.action = ACT_REQUEST;
    else x.action = ACT_TICK;
    return x;
  endfunction

  // Request driver: a new word goes out at the falling edge once the last one was taken.
  always @(posedge clk) req_took <= req_valid && req_ready;

  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_took) begin
      if (stim_q.size() > 0 &&
          $urandom_range(99) >= ((idle_mode == MODE_SEND) ? 46 :
                                 (idle_mode == MODE_BOTH) ? 19 : 0)) begin
        req_word <= stim_q.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Response side: a long hold-off, when requested, comes before the random stalls.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= $urandom_range(99) >= ((idle_mode == MODE_RECV) ? 46 :
                                         (idle_mode == MODE_BOTH) ? 19 : 0);
    end
  end

  // Accepted request words feed the predictor; accepted response words are checked.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst) begin
      if (req_valid && req_ready) expected_q = {expected_q, predict_response(req_word)};
      if (rsp_valid && rsp_ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response word %h", rsp_word);
        end else begin
          want = expected_q.pop_front();
          if (rsp_word.status !== want.status ||
              rsp_word.used_bytes !== want.used_bytes ||
              rsp_word.pending_requests !== want.pending_requests ||
              rsp_word.evicted_total !== want.evicted_total ||
              rsp_word.entry_count !== want.entry_count ||
              rsp_word.loads_done !== want.loads_done) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: status %0d/%0d used %0d/%0d pending %0d/%0d",
                       want.status, rsp_word.status, want.used_bytes, rsp_word.used_bytes,
                       want.pending_requests, rsp_word.pending_requests,
                       "  evicted %0d/%0d entries %0d/%0d loads %0d/%0d (expected/actual)",
                       want.evicted_total, rsp_word.evicted_total,
                       want.entry_count, rsp_word.entry_count,
                       want.loads_done, rsp_word.loads_done);
          end
        end
      end
    end
  end

  // Waits until every queued word was sent and answered, then lets the block settle.
  task automatic drain();
    do @(posedge clk); while (stim_q.size() > 0 || req_valid || expected_q.size() > 0);
    repeat (10) @(posedge clk);
  endtask

  // Register write; the shadow copy changes at the edge that takes the word.
  task automatic write_reg(logic [1:0] idx, logic [39:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_BUDGET) budget = val;
    else loads_limit = val[3:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_random(int n, int reg_pct, int unreg_pct, int req_pct);
    pool_base = 16'($urandom);
    for (int i = 0; i < n; i++) stim_add(rand_word(reg_pct, unreg_pct, req_pct));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at reset configuration: size extremes, clamping, duplicate,
    // unknown handles, every priority and a few ticks.
    stim_add(make_word(ACT_REGISTER, 16'h0000, 0, 0, 0, 0, PRIO_IMMEDIATE));
    stim_add(make_word(ACT_REGISTER, 16'hFFFF, 32767, 32767, 15, 15, PRIO_LOW));
    stim_add(make_word(ACT_REGISTER, 16'hFFFF, 8, 8, 2, 0, PRIO_HIGH));
    stim_add(make_word(ACT_REGISTER, 16'h1234, 16384, 1, 1, 0, PRIO_NORMAL));
    stim_add(make_word(ACT_REGISTER, 16'h5A5A, 16384, 16384, 12, 0, PRIO_NORMAL));
    stim_add(make_word(ACT_REQUEST, 16'hFFFF, 0, 0, 0, 0, PRIO_IMMEDIATE));
    stim_add(make_word(ACT_REQUEST, 16'h0000, 0, 0, 0, 15, PRIO_LOW));
    stim_add(make_word(ACT_REQUEST, 16'h5A5A, 0, 0, 0, 3, PRIO_HIGH));
    stim_add(make_word(ACT_REQUEST, 16'h1234, 0, 0, 0, 15, PRIO_NORMAL));
    stim_add(make_word(ACT_REQUEST, 16'hBEEF, 0, 0, 0, 1, PRIO_HIGH));
    stim_add(make_word(ACT_TICK, 16'hFFFF, 32767, 32767, 15, 15, PRIO_LOW));
    stim_add(make_word(ACT_UNREGISTER, 16'hBEEF, 0, 0, 0, 0, PRIO_IMMEDIATE));
    stim_add(make_word(ACT_REQUEST, 16'h5A5A, 0, 0, 0, 11, PRIO_LOW));
    stim_add(make_word(ACT_REQUEST, 16'hFFFF, 0, 0, 0, 5, PRIO_NORMAL));
    stim_add(make_word(ACT_TICK, 16'h0000, 0, 0, 0, 0, PRIO_IMMEDIATE));
    stim_add(make_word(ACT_UNREGISTER, 16'h0000, 0, 0, 0, 0, PRIO_IMMEDIATE));
    stim_add(make_word(ACT_UNREGISTER, 16'h5A5A, 0, 0, 0, 0, PRIO_IMMEDIATE));
    stim_add(make_word(ACT_TICK, 16'h0000, 0, 0, 0, 0, PRIO_IMMEDIATE));
    drain();

    // Largest budget and most loads per tick, sender idling.
    write_reg(REG_BUDGET, USED_MAX);
    write_reg(REG_LOADS, 40'd15);
    idle_mode = MODE_SEND;
    queue_random(250, 30, 12, 38);
    drain();

    // Zero budget, one load per tick, receiver stalling. A long hold-off up front
    // lets a response sit in the output register while words keep being offered.
    write_reg(REG_BUDGET, '0);
    write_reg(REG_LOADS, 40'd1);
    idle_mode = MODE_RECV;
    hold_request = 600;
    queue_random(250, 30, 12, 38);
    drain();

    // Mid budget, no loads per tick, heavy registration so the table fills up.
    write_reg(REG_BUDGET, 40'($urandom_range(1 << 20, 1 << 24)));
    write_reg(REG_LOADS, '0);
    idle_mode = MODE_BOTH;
    pool_base = 16'($urandom);
    for (int i = 0; i < 200; i++)
      stim_add(make_word(ACT_REGISTER, pool_base + 16'(i % 80), rand_dim(), rand_dim(),
                         $urandom_range(15), $urandom_range(15), 2'($urandom_range(3))));
    for (int i = 0; i < 40; i++) stim_add(rand_word(20, 10, 40));
    drain();

    // Random middle settings, no idling.
    write_reg(REG_BUDGET, {8'($urandom_range(3)), 32'($urandom)});
    write_reg(REG_LOADS, 40'($urandom_range(2, 14)));
    idle_mode = MODE_BUSY;
    queue_random(300, 25, 20, 35);
    drain();
    repeat (50) @(posedge clk);

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/mrbm_pkg.sv
hw/rtl/mrbm_ram.sv
hw/rtl/mrbm_mip_size.sv
hw/rtl/mip_residency_budget_manager_top.sv
test/mip_residency_budget_manager_top_tb.sv
